### rtl/bifl_pkg.sv
// Shared types and constants for the buffer index free list.
package bifl_pkg;

  localparam int DEPTH    = 256;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic restart;
  } ctrl_cmd_t;

endpackage

### rtl/bifl_ctrl.sv
// Controller: sequences one transaction at a time and owns the result valid flag.
module bifl_ctrl import bifl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   in_acc;
  logic   out_free;

  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready   = 1'b0;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    cmd.restart = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cfg_ready   = 1'b1;
        in_ready    = ~cfg_valid;
        cmd.capture = in_valid & ~cfg_valid;
        cmd.restart = cfg_valid;
      end
      ST_EXEC: begin
        cmd.commit = out_free;
      end
      default: ;
    endcase
  end

  // result register: loaded on commit, emptied when taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_commit_in_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> state == ST_EXEC)
    else $error("commit outside execute state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && out_valid) |-> out_ready)
    else $error("result overwritten before it was taken");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_EXEC))
    else $error("accepted transaction not executed");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (state == ST_IDLE && !in_acc))
    else $error("config write collides with a transaction");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid without commit");

endmodule

### rtl/bifl_datapath.sv
// Datapath: pool counters, lease marks, return stack memory and result register.
module bifl_datapath import bifl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  input  logic [CNT_W-1:0]    cfg_data,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [IDX_W-1:0]    in_index,
  output logic [STATUS_W-1:0] res_status,
  output logic [IDX_W-1:0]    res_index,
  output logic [CNT_W-1:0]    res_free
);

  logic [CNT_W-1:0]    pool_size;
  logic [CNT_W-1:0]    returned_count;
  logic [CNT_W-1:0]    returned_count_next;
  logic [CNT_W-1:0]    next_fresh;
  logic [CNT_W-1:0]    next_fresh_next;
  logic [DEPTH-1:0]    lease_marks;
  logic [IDX_W-1:0]    stack_mem [DEPTH];
  logic [IDX_W-1:0]    stack_rd;
  logic [IDX_W-1:0]    rd_addr;
  logic [CMD_W-1:0]    cmd_q;
  logic [IDX_W-1:0]    idx_q;
  logic                leased;
  logic                set_lease;
  logic                clr_lease;
  logic                push;
  logic [IDX_W-1:0]    grant;
  status_t             status;
  logic [CNT_W-1:0]    pool_clamped;
  logic [CNT_W-1:0]    free_next;

  // zero acts as one, anything beyond the stack depth acts as the depth
  always_comb begin
    pool_clamped = cfg_data;
    if (cfg_data == '0) pool_clamped = CNT_W'(1);
    else if (cfg_data > CNT_W'(DEPTH)) pool_clamped = CNT_W'(DEPTH);
  end

  assign rd_addr = IDX_W'(returned_count - CNT_W'(1));
  assign leased  = ({1'b0, idx_q} < pool_size) & lease_marks[idx_q];

  always_comb begin
    returned_count_next = returned_count;
    next_fresh_next     = next_fresh;
    set_lease           = 1'b0;
    clr_lease           = 1'b0;
    push                = 1'b0;
    grant               = idx_q;
    status              = STATUS_ERROR;
    unique case (cmd_q)
      CMD_ACQUIRE: begin
        if (returned_count != '0) begin
          returned_count_next = returned_count - CNT_W'(1);
          grant               = stack_rd;
          set_lease           = 1'b1;
          status              = STATUS_OK;
        end else if (next_fresh < pool_size) begin
          next_fresh_next = next_fresh + CNT_W'(1);
          grant           = IDX_W'(next_fresh);
          set_lease       = 1'b1;
          status          = STATUS_OK;
        end else begin
          grant  = '0;
          status = STATUS_EMPTY;
        end
      end
      CMD_RELEASE: begin
        if (leased && returned_count != CNT_W'(DEPTH)) begin
          returned_count_next = returned_count + CNT_W'(1);
          clr_lease           = 1'b1;
          push                = 1'b1;
          status              = STATUS_OK;
        end
      end
      CMD_CHECK: begin
        if (leased) status = STATUS_OK;
      end
      default: ;
    endcase
  end

  assign free_next = returned_count_next + (pool_size - next_fresh_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size      <= CNT_W'(DEPTH);
      returned_count <= '0;
      next_fresh     <= '0;
      lease_marks    <= '0;
    end else if (cmd.restart) begin
      pool_size      <= pool_clamped;
      returned_count <= '0;
      next_fresh     <= '0;
      lease_marks    <= '0;
    end else if (cmd.commit) begin
      returned_count <= returned_count_next;
      next_fresh     <= next_fresh_next;
      if (set_lease) lease_marks[grant] <= 1'b1;
      if (clr_lease) lease_marks[idx_q] <= 1'b0;
    end
  end

  // top of stack is read every cycle; it is stable while idle
  always_ff @(posedge clk) begin
    if (cmd.commit && push) stack_mem[IDX_W'(returned_count)] <= idx_q;
    stack_rd <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= in_command;
      idx_q <= in_index;
    end
    if (cmd.commit) begin
      res_status <= status;
      res_index  <= grant;
      res_free   <= free_next;
    end
  end

endmodule

### rtl/buffer_index_free_list.sv
// Top level of the buffer index free list allocator.
// Hands out buffer indices, fresh ones ascending from 0, released ones
// most recently released first, and tracks which indices are leased.
// Input stream: tuser carries the command (acquire, release, check),
// tdata the buffer index to release or check.
// Output stream: one result per transaction; tuser carries the status,
// tdata the granted or echoed index and the free count after the item.
// Config channel: writing pool_size restarts the pool; it is taken only
// while no transaction is in flight.
// Each transaction is accepted in idle, where the top of the return stack
// is read from its registered memory port, then runs in execute, which loads
// the result register; the next is accepted only once execute is left.
// If the receiver stalls, one result waits in the output register and the
// next transaction is still accepted; it then holds in execute until the
// waiting result is taken.
// Reset: pool_size 256, no index leased, return stack empty.
module buffer_index_free_list import bifl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] index to release or check
  input  logic [CMD_W-1:0]       s_axis_tuser,  // [1:0] command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata,  // [7:0] granted_index, [16:8] free_count
  output logic [STATUS_W-1:0]    m_axis_tuser   // [1:0] status
);

  ctrl_cmd_t        cmd;
  logic [IDX_W-1:0] res_index;
  logic [CNT_W-1:0] res_free;

  bifl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  bifl_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_data   (cfg_data),
    .in_command (s_axis_tuser),
    .in_index   (s_axis_tdata[IDX_W-1:0]),
    .res_status (m_axis_tuser),
    .res_index  (res_index),
    .res_free   (res_free)
  );

  assign m_axis_tdata = {7'd0, res_free, res_index};

endmodule
